// ===== rtl/core/srdg_pkg.sv =====
// ----------------------------------------------------------------------------
// srdg_pkg
// Shared types and constants of the stepper ramp delay generator.
// ----------------------------------------------------------------------------
package srdg_pkg;

    // default sizing
    localparam int MAX_STEPS_DEF = 256;
    localparam int FRAC_BITS_DEF = 8;

    // fixed field widths
    localparam int DELAY_W = 16;
    localparam int COUNT_W = 9;

    // floor register reset value
    localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 16'd10;

    // move phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_DECEL = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic do_start;     // load a new move and emit its first step
        logic accel_go;     // launch the ramp division
        logic accel_fin;    // finish an accelerating step
        logic dec_read;     // read the store for a slowing step
        logic dec_cap;      // capture the store read data
        logic do_idle;      // build the idle result
        logic load_out;     // move the result into the output register
    } srdg_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] phase;
        logic       div_done;
        logic       out_free;
    } srdg_sts_t;

endpackage

// ===== rtl/core/srdg_divider.sv =====
// ----------------------------------------------------------------------------
// srdg_divider
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srdg_divider
    import srdg_pkg::*;
#(
    parameter int DVD_W = 25,
    parameter int DV_W  = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DV_W-1:0]  divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DV_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DV_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DV_W:0]    trial;
    logic [DV_W:0]    diff;

    // one shift and trial subtract per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (go)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[DV_W])
            begin
                rem_next = diff[DV_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DV_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/srdg_datapath.sv =====
// ----------------------------------------------------------------------------
// srdg_datapath
// Ramp state, delay store, divider and result registers.
// ----------------------------------------------------------------------------
module srdg_datapath
    import srdg_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  srdg_cmd_t          cmd,
    output srdg_sts_t          sts,
    input  logic [DELAY_W-1:0] initial_delay,
    input  logic [COUNT_W-1:0] step_count,
    input  logic               direction,
    input  logic [DELAY_W-1:0] min_delay,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [23:0]        m_tdata,   // delay_us, move_dir, decelerating, zero pad
    output logic               m_tlast,   // last_step
    output logic               m_tuser    // idle
);

    localparam int D_W   = DELAY_W + FRAC_BITS;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int IDX_W = $clog2(MAX_STEPS);
    localparam int DV_W  = IDX_W + 2;
    localparam int DVD_W = D_W + 1;
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // ramp state
    logic [D_W-1:0]     delay_reg, delay_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [1:0]         phase_reg, phase_next;
    logic               dir_reg, dir_next;

    // pending result
    logic [DELAY_W-1:0] res_delay_reg, res_delay_next;
    logic               res_dir_reg, res_dir_next;
    logic               res_dec_reg, res_dec_next;
    logic               res_last_reg, res_last_next;
    logic               res_idle_reg, res_idle_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [DELAY_W-1:0] out_delay_reg;
    logic               out_dir_reg, out_dec_reg, out_last_reg, out_idle_reg;

    // delay store
    logic [DELAY_W-1:0] store_mem [MAX_STEPS];
    logic [DELAY_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [DELAY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   rd_pos;

    // arithmetic
    logic [D_W-1:0]     floor_lim;
    logic [D_W-1:0]     d_init, d_init_f;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CNT_W-1:0]   cnt_clamp;
    logic [DVD_W-1:0]   quotient;
    logic [DVD_W-1:0]   diff;
    logic [D_W-1:0]     d_ramp, d_ramp_f;
    logic [CNT_W-1:0]   step_inc;
    logic               div_done;

    srdg_divider #(
        .DVD_W (DVD_W),
        .DV_W  (DV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.accel_go),
        .dividend ({delay_reg, 1'b0}),
        .divisor  ({step_reg[IDX_W-1:0], 2'b01}),
        .done     (div_done),
        .quotient (quotient)
    );

    // floor, start delay, count clamp, ramp step and store read address
    always_comb
    begin
        floor_lim = D_W'(min_delay) << FRAC_BITS;
        d_init    = D_W'(initial_delay) << FRAC_BITS;
        d_init_f  = (d_init < floor_lim) ? floor_lim : d_init;
        cnt_ext   = CMP_W'(step_count);
        if (cnt_ext == '0)
            cnt_clamp = CNT_W'(1);
        else if (cnt_ext > CMP_W'(MAX_STEPS))
            cnt_clamp = CNT_W'(MAX_STEPS);
        else
            cnt_clamp = CNT_W'(cnt_ext);
        diff     = {1'b0, delay_reg} - quotient;
        d_ramp   = diff[D_W-1:0];
        d_ramp_f = (d_ramp < floor_lim) ? floor_lim : d_ramp;
        step_inc = step_reg + 1'b1;
        rd_pos   = len_reg - 1'b1 - step_reg;
        rd_addr  = rd_pos[IDX_W-1:0];
    end

    // next state of the ramp and the pending result
    always_comb
    begin
        delay_next     = delay_reg;
        step_next      = step_reg;
        len_next       = len_reg;
        phase_next     = phase_reg;
        dir_next       = dir_reg;
        res_delay_next = res_delay_reg;
        res_dir_next   = res_dir_reg;
        res_dec_next   = res_dec_reg;
        res_last_next  = res_last_reg;
        res_idle_next  = res_idle_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        if (cmd.do_start)
        begin
            delay_next = d_init_f;
            len_next   = cnt_clamp;
            dir_next   = direction;
            if (cnt_clamp == CNT_W'(1))
            begin
                phase_next = PH_DECEL;
                step_next  = '0;
            end
            else
            begin
                phase_next = PH_ACCEL;
                step_next  = CNT_W'(1);
            end
            wr_en          = 1'b1;
            wr_data        = d_init_f[FRAC_BITS +: DELAY_W];
            res_delay_next = d_init_f[FRAC_BITS +: DELAY_W];
            res_dir_next   = direction;
            res_dec_next   = 1'b0;
            res_last_next  = 1'b0;
            res_idle_next  = 1'b0;
        end
        else if (cmd.accel_fin)
        begin
            delay_next = d_ramp_f;
            if (step_inc >= len_reg)
            begin
                phase_next = PH_DECEL;
                step_next  = '0;
            end
            else
            begin
                step_next = step_inc;
            end
            wr_en          = 1'b1;
            wr_addr        = step_reg[IDX_W-1:0];
            wr_data        = d_ramp_f[FRAC_BITS +: DELAY_W];
            res_delay_next = d_ramp_f[FRAC_BITS +: DELAY_W];
            res_dir_next   = dir_reg;
            res_dec_next   = 1'b0;
            res_last_next  = 1'b0;
            res_idle_next  = 1'b0;
        end
        else if (cmd.dec_read)
        begin
            if (step_inc >= len_reg)
            begin
                phase_next    = PH_IDLE;
                step_next     = '0;
                res_last_next = 1'b1;
            end
            else
            begin
                step_next     = step_inc;
                res_last_next = 1'b0;
            end
            res_dir_next  = dir_reg;
            res_dec_next  = 1'b1;
            res_idle_next = 1'b0;
        end
        else if (cmd.dec_cap)
        begin
            res_delay_next = rd_data_reg;
        end
        else if (cmd.do_idle)
        begin
            phase_next     = PH_IDLE;
            res_delay_next = '0;
            res_dir_next   = 1'b0;
            res_dec_next   = 1'b0;
            res_last_next  = 1'b0;
            res_idle_next  = 1'b1;
        end
    end

    // output register handshake
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= '0;
            step_reg      <= '0;
            len_reg       <= '0;
            phase_reg     <= PH_IDLE;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            delay_reg     <= delay_next;
            step_reg      <= step_next;
            len_reg       <= len_next;
            phase_reg     <= phase_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        res_delay_reg <= res_delay_next;
        res_dir_reg   <= res_dir_next;
        res_dec_reg   <= res_dec_next;
        res_last_reg  <= res_last_next;
        res_idle_reg  <= res_idle_next;
        if (cmd.load_out)
        begin
            out_delay_reg <= res_delay_reg;
            out_dir_reg   <= res_dir_reg;
            out_dec_reg   <= res_dec_reg;
            out_last_reg  <= res_last_reg;
            out_idle_reg  <= res_idle_reg;
        end
    end

    // delay store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        if (cmd.dec_read)
            rd_data_reg <= store_mem[rd_addr];
    end

    assign sts.phase    = phase_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_dec_reg, out_dir_reg, out_delay_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_idle_reg;

endmodule

// ===== rtl/core/srdg_ctrl.sv =====
// ----------------------------------------------------------------------------
// srdg_ctrl
// Sequencer for one request: decode, ramp division or store read, hand-off.
// ----------------------------------------------------------------------------
module srdg_ctrl
    import srdg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      start_req,
    input  srdg_sts_t sts,
    output srdg_cmd_t cmd
);

    localparam logic [1:0] ST_WAIT = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    // state transitions and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_WAIT:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (start_req)
                    begin
                        cmd.do_start = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (sts.phase == PH_ACCEL)
                    begin
                        cmd.accel_go = 1'b1;
                        state_next   = ST_DIV;
                    end
                    else if (sts.phase == PH_DECEL)
                    begin
                        cmd.dec_read = 1'b1;
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        cmd.do_idle = 1'b1;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.accel_fin = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.dec_cap = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_WAIT;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_WAIT;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/core/stepper_ramp_delay_generator_top.sv =====
// ----------------------------------------------------------------------------
// stepper_ramp_delay_generator_top
// Per-step pulse delays of a symmetric accelerate / decelerate stepper move.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one transfer per step request. s_tuser = start_req; a start
//   loads initial_delay, step_count and direction and yields the first step.
//   m_* channel: one transfer per request with the step delay, direction and
//   phase flag in m_tdata, last_step on m_tlast and idle on m_tuser.
//   APB port: register 0 at address 0 is min_delay, the delay floor.
// Timing
//   Requests are handled one at a time. A start or idle request goes through
//   the ST_DONE state to the output register; a slowing step first reads the
//   delay store, an accelerating step first waits for the bit-serial divider
//   that forms 2d/(4i+1) one quotient bit per cycle.
//   The output register frees the engine, so the next request is taken while
//   a result waits; a stalled receiver holds the engine only once a second
//   result is ready.
// Reset
//   rst_n clears the move state to idle and min_delay to 10; the delay store
//   is not cleared, a move only replays entries it wrote itself.
// ----------------------------------------------------------------------------
module stepper_ramp_delay_generator_top
    import srdg_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // initial_delay[15:0], step_count[24:16], direction[25]
    input  logic        s_tuser,   // start_req
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // delay_us[15:0], move_dir[16], decelerating[17]
    output logic        m_tlast,   // last_step
    output logic        m_tuser,   // idle
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DELAY_W-1:0] min_delay_reg, min_delay_next;
    logic               reg_sel;
    srdg_cmd_t          cmd;
    srdg_sts_t          sts;

    // register decode and write
    assign reg_sel = (paddr[2] == 1'b0);

    always_comb
    begin
        min_delay_next = min_delay_reg;
        if (psel && penable && pwrite && reg_sel)
            min_delay_next = pwdata[DELAY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_delay_reg <= MIN_DELAY_RST;
        else
            min_delay_reg <= min_delay_next;
    end

    assign prdata = reg_sel ? {16'b0, min_delay_reg} : 32'b0;
    assign pready = 1'b1;

    srdg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .start_req (s_tuser),
        .sts       (sts),
        .cmd       (cmd)
    );

    srdg_datapath #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .initial_delay (s_tdata[15:0]),
        .step_count    (s_tdata[24:16]),
        .direction     (s_tdata[25]),
        .min_delay     (min_delay_reg),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser)
    );

endmodule
